// ===== hw/rtl/text_console_cursor_engine_top_defines.svh =====
// Assertion macros for the console engine checker.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// General property, clocked on clk_i, off during reset.
`define TCCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property that applies whenever a result item is offered.
`define TCCE_ASSERT_RSP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid_i |-> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcce_pkg.sv =====
package tcce_pkg;

  localparam int unsigned ColumnsDefault = 80;
  localparam int unsigned RowsDefault    = 25;

  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned CharW    = 8;
  localparam int unsigned AttrW    = 8;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned PosW     = 11;
  localparam int unsigned CellW    = CharW + AttrW;

  localparam logic [CharW-1:0] ChNewline   = 8'h0A;
  localparam logic [CharW-1:0] ChReturn    = 8'h0D;
  localparam logic [CharW-1:0] ChBackspace = 8'h08;
  localparam logic [CharW-1:0] ChTab       = 8'h09;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;

  localparam int unsigned TabStop = 8;

  localparam logic [AttrW-1:0] AttrReset = 8'h07;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } tcce_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SWEEP,
    ST_DONE
  } tcce_state_e;

  // Actions decided by the cursor step for one put.
  typedef struct packed {
    logic wr_char;
    logic bs_fix;
    logic scroll;
  } tcce_act_t;

endpackage

// ===== hw/rtl/tcce_if.sv =====
interface tcce_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::AttrW-1:0]    text_attribute;

  modport source (output valid, output text_attribute, input ready);
  modport sink (input valid, input text_attribute, output ready);
endinterface

interface tcce_req_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::ReqTypeW-1:0] req_type;
  logic [tcce_pkg::CharW-1:0]    char_code;
  logic [tcce_pkg::IdxW-1:0]     cell_index;

  modport source (output valid, output req_type, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input req_type, input char_code, input cell_index,
                output ready);
endinterface

interface tcce_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::PosW-1:0]     cursor_pos;
  logic [tcce_pkg::CharW-1:0]    cell_char;
  logic [tcce_pkg::AttrW-1:0]    cell_attr;
  logic                          scrolled;

  modport source (output valid, output cursor_pos, output cell_char, output cell_attr,
                  output scrolled, input ready);
  modport sink (input valid, input cursor_pos, input cell_char, input cell_attr,
                input scrolled, output ready);
endinterface

// ===== hw/rtl/tcce_cursor.sv =====
module tcce_cursor #(
  parameter int unsigned COLUMNS = tcce_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = tcce_pkg::RowsDefault,
  localparam int unsigned ColW   = $clog2(COLUMNS),
  localparam int unsigned RowW   = $clog2(ROWS)
) (
  input  logic [ColW-1:0]           col_i,
  input  logic [RowW-1:0]           row_i,
  input  logic [tcce_pkg::CharW-1:0] char_i,
  output logic [ColW-1:0]           col_o,
  output logic [RowW-1:0]           row_o,
  output tcce_pkg::tcce_act_t       act_o
);

  logic [ColW:0] col_w;
  logic [RowW:0] row_w;

  always_comb begin
    col_w = {1'b0, col_i};
    row_w = {1'b0, row_i};
    act_o = '0;
    case (char_i)
      tcce_pkg::ChNewline: begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      tcce_pkg::ChReturn: begin
        col_w = '0;
      end
      tcce_pkg::ChBackspace: begin
        if (col_i != '0) begin
          col_w        = col_w - 1'b1;
          act_o.bs_fix = 1'b1;
        end
      end
      tcce_pkg::ChTab: begin
        col_w = (col_w + (ColW+1)'(tcce_pkg::TabStop)) & ~(ColW+1)'(tcce_pkg::TabStop - 1);
      end
      default: begin
        col_w         = col_w + 1'b1;
        act_o.wr_char = 1'b1;
      end
    endcase
    if (col_w >= (ColW+1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    if (row_w >= (RowW+1)'(ROWS)) begin
      act_o.scroll = 1'b1;
      row_w        = (RowW+1)'(ROWS - 1);
    end
  end

  assign col_o = col_w[ColW-1:0];
  assign row_o = row_w[RowW-1:0];

endmodule

// ===== hw/rtl/text_console_cursor_engine_top.sv =====
// channel   dir  handshake     payload
// cfg_i     in   valid/ready   text_attribute
// req_i     in   valid/ready   req_type, char_code, cell_index
// rsp_o     out  valid/ready   cursor_pos, cell_char, cell_attr, scrolled
//
// One item at a time. Put, read and unused codes pass through EXEC, then RDWAIT
// for an in-range read or a backspace that moves, then DONE; a put that scrolls and a
// clear walk the screen RAM one cell per cycle in SWEEP before DONE. After reset the
// RAM is swept once before req_i is ready; cfg_i is always ready. rsp_o is registered,
// so the next item is taken while a result waits; it completes when rsp_o frees up.
module text_console_cursor_engine_top #(
  parameter int unsigned COLUMNS = tcce_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = tcce_pkg::RowsDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  tcce_cfg_if.sink   cfg_i,
  tcce_req_if.sink   req_i,
  tcce_rsp_if.source rsp_o
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned CopyEnd   = CellCount - COLUMNS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned ColW      = $clog2(COLUMNS);
  localparam int unsigned RowW      = $clog2(ROWS);
  localparam int unsigned CharW     = tcce_pkg::CharW;
  localparam int unsigned AttrW     = tcce_pkg::AttrW;
  localparam int unsigned CellW     = tcce_pkg::CellW;

  tcce_pkg::tcce_state_e state_q, state_d;

  logic [AttrW-1:0] attr_q, attr_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;

  logic [tcce_pkg::ReqTypeW-1:0] req_type_q;
  logic [CharW-1:0]              char_code_q;
  logic [tcce_pkg::IdxW-1:0]     cell_index_q;

  logic [AddrW-1:0] swp_idx_q, swp_idx_d;
  logic             swp_copy_q, swp_copy_d;
  logic             swp_resp_q, swp_resp_d;
  logic [AttrW-1:0] fill_attr_q, fill_attr_d;

  logic [CharW-1:0] res_char_q, res_char_d;
  logic [AttrW-1:0] res_attr_q, res_attr_d;
  logic             res_scroll_q, res_scroll_d;

  logic                      out_vld_q, out_vld_d;
  logic [tcce_pkg::PosW-1:0] out_pos_q, out_pos_d;
  logic [CharW-1:0]          out_char_q, out_char_d;
  logic [AttrW-1:0]          out_attr_q, out_attr_d;
  logic                      out_scroll_q, out_scroll_d;

  logic             wr_vld_q, wr_vld_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic             wr_copy_q, wr_copy_d;
  logic [CellW-1:0] wr_data_q, wr_data_d;

  logic [CellW-1:0] mem [CellCount];
  logic [CellW-1:0] rdata_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [CellW-1:0] wd;

  logic [AddrW-1:0]    pos;
  logic [ColW-1:0]     cur_col;
  logic [RowW-1:0]     cur_row;
  tcce_pkg::tcce_act_t act;
  logic                idx_ok;
  logic                copy;
  logic                req_fire;

  tcce_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_tcce_cursor (
    .col_i (col_q),
    .row_i (row_q),
    .char_i(char_code_q),
    .col_o (cur_col),
    .row_o (cur_row),
    .act_o (act)
  );

  assign pos      = AddrW'(row_q * COLUMNS) + AddrW'(col_q);
  assign idx_ok   = 32'(cell_index_q) < CellCount;
  assign copy     = swp_copy_q && (swp_idx_q < AddrW'(CopyEnd));
  assign req_fire = req_i.valid && req_i.ready;
  assign wd       = wr_copy_q ? rdata_q : wr_data_q;

  assign cfg_i.ready      = 1'b1;
  assign attr_d           = cfg_i.valid ? cfg_i.text_attribute : attr_q;
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.cursor_pos = out_pos_q;
  assign rsp_o.cell_char  = out_char_q;
  assign rsp_o.cell_attr  = out_attr_q;
  assign rsp_o.scrolled   = out_scroll_q;

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    swp_idx_d    = swp_idx_q;
    swp_copy_d   = swp_copy_q;
    swp_resp_d   = swp_resp_q;
    fill_attr_d  = fill_attr_q;
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    res_scroll_d = res_scroll_q;
    out_vld_d    = out_vld_q;
    out_pos_d    = out_pos_q;
    out_char_d   = out_char_q;
    out_attr_d   = out_attr_q;
    out_scroll_d = out_scroll_q;
    wr_vld_d     = 1'b0;
    wr_addr_d    = wr_addr_q;
    wr_copy_d    = 1'b0;
    wr_data_d    = wr_data_q;
    rd_en        = 1'b0;
    rd_addr      = pos;
    req_i.ready  = 1'b0;

    if (rsp_o.valid && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      tcce_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = tcce_pkg::ST_EXEC;
        end
      end
      tcce_pkg::ST_EXEC: begin
        res_char_d   = '0;
        res_attr_d   = '0;
        res_scroll_d = 1'b0;
        state_d      = tcce_pkg::ST_DONE;
        case (tcce_pkg::tcce_req_e'(req_type_q))
          tcce_pkg::REQ_PUT: begin
            col_d = cur_col;
            row_d = cur_row;
            if (act.wr_char) begin
              wr_vld_d  = 1'b1;
              wr_addr_d = pos;
              wr_data_d = {attr_q, char_code_q};
            end
            if (act.bs_fix) begin
              rd_en   = 1'b1;
              rd_addr = pos - 1'b1;
              state_d = tcce_pkg::ST_RDWAIT;
            end else if (act.scroll) begin
              res_scroll_d = 1'b1;
              swp_idx_d    = '0;
              swp_copy_d   = 1'b1;
              swp_resp_d   = 1'b1;
              fill_attr_d  = attr_q;
              state_d      = tcce_pkg::ST_SWEEP;
            end
          end
          tcce_pkg::REQ_READ: begin
            if (idx_ok) begin
              rd_en   = 1'b1;
              rd_addr = AddrW'(cell_index_q);
              state_d = tcce_pkg::ST_RDWAIT;
            end
          end
          tcce_pkg::REQ_CLEAR: begin
            col_d       = '0;
            row_d       = '0;
            swp_idx_d   = '0;
            swp_copy_d  = 1'b0;
            swp_resp_d  = 1'b1;
            fill_attr_d = attr_q;
            state_d     = tcce_pkg::ST_SWEEP;
          end
          default: begin
            state_d = tcce_pkg::ST_DONE;
          end
        endcase
      end
      tcce_pkg::ST_RDWAIT: begin
        // backspace keeps the attribute of the cell it blanks
        if (tcce_pkg::tcce_req_e'(req_type_q) == tcce_pkg::REQ_PUT) begin
          wr_vld_d  = 1'b1;
          wr_addr_d = pos;
          wr_data_d = {rdata_q[CellW-1:CharW], tcce_pkg::ChSpace};
        end else begin
          res_char_d = rdata_q[CharW-1:0];
          res_attr_d = rdata_q[CellW-1:CharW];
        end
        state_d = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_SWEEP: begin
        // read row below into rdata_q; the registered write copies it from there
        rd_en     = copy;
        rd_addr   = swp_idx_q + AddrW'(COLUMNS);
        wr_vld_d  = 1'b1;
        wr_addr_d = swp_idx_q;
        wr_copy_d = copy;
        wr_data_d = {fill_attr_q, tcce_pkg::ChSpace};
        if (swp_idx_q == AddrW'(CellCount - 1)) begin
          state_d = swp_resp_q ? tcce_pkg::ST_DONE : tcce_pkg::ST_IDLE;
        end else begin
          swp_idx_d = swp_idx_q + 1'b1;
        end
      end
      tcce_pkg::ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_pos_d    = tcce_pkg::PosW'(pos);
          out_char_d   = res_char_q;
          out_attr_d   = res_attr_q;
          out_scroll_d = res_scroll_q;
          state_d      = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcce_pkg::ST_SWEEP;
      attr_q      <= tcce_pkg::AttrReset;
      col_q       <= '0;
      row_q       <= '0;
      swp_idx_q   <= '0;
      swp_copy_q  <= 1'b0;
      swp_resp_q  <= 1'b0;
      fill_attr_q <= tcce_pkg::AttrReset;
      out_vld_q   <= 1'b0;
      wr_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      attr_q      <= attr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      swp_idx_q   <= swp_idx_d;
      swp_copy_q  <= swp_copy_d;
      swp_resp_q  <= swp_resp_d;
      fill_attr_q <= fill_attr_d;
      out_vld_q   <= out_vld_d;
      wr_vld_q    <= wr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_type_q   <= req_i.req_type;
      char_code_q  <= req_i.char_code;
      cell_index_q <= req_i.cell_index;
    end
    res_char_q   <= res_char_d;
    res_attr_q   <= res_attr_d;
    res_scroll_q <= res_scroll_d;
    out_pos_q    <= out_pos_d;
    out_char_q   <= out_char_d;
    out_attr_q   <= out_attr_d;
    out_scroll_q <= out_scroll_d;
    wr_addr_q    <= wr_addr_d;
    wr_copy_q    <= wr_copy_d;
    wr_data_q    <= wr_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_vld_q) begin
      mem[wr_addr_q] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/tcce_checker.sv =====
`include "text_console_cursor_engine_top_defines.svh"

module tcce_checker #(
  parameter int unsigned COLUMNS = tcce_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = tcce_pkg::RowsDefault
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [tcce_pkg::PosW-1:0]      cursor_pos_i,
  input logic [tcce_pkg::CharW-1:0]     cell_char_i,
  input logic [tcce_pkg::AttrW-1:0]     cell_attr_i,
  input logic                           scrolled_i
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam logic [tcce_pkg::PosW-1:0] LastRowPos = tcce_pkg::PosW'((ROWS - 1) * COLUMNS);
  localparam int unsigned RspW = tcce_pkg::PosW + tcce_pkg::CharW + tcce_pkg::AttrW + 1;

  logic            req_fire;
  logic            rsp_stall;
  logic            rsp_cell_zero;
  logic [RspW-1:0] rsp_item;

  assign req_fire      = req_valid_i && req_ready_i;
  assign rsp_stall     = rsp_valid_i && !rsp_ready_i;
  assign rsp_cell_zero = (cell_char_i == '0) && (cell_attr_i == '0);
  assign rsp_item      = {cursor_pos_i, cell_char_i, cell_attr_i, scrolled_i};

  `TCCE_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid_i && $stable(rsp_item), "rsp item changed")
  `TCCE_ASSERT(a_one_item, req_fire |=> !req_ready_i, "second item taken while busy")
  `TCCE_ASSERT_RSP(a_pos_range, 32'(cursor_pos_i) < CellCount, "cursor off screen")
  `TCCE_ASSERT_RSP(a_scroll_pos, !scrolled_i || cursor_pos_i == LastRowPos, "bad scroll cursor")
  `TCCE_ASSERT_RSP(a_scroll_cell, !scrolled_i || rsp_cell_zero, "cell data on scroll")

endmodule

bind text_console_cursor_engine_top tcce_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .cursor_pos_i(rsp_o.cursor_pos),
  .cell_char_i (rsp_o.cell_char),
  .cell_attr_i (rsp_o.cell_attr),
  .scrolled_i  (rsp_o.scrolled)
);
